@@ rtl/core/psi_svt_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// psi_svt_pkg
// Shared types and constants of the PSI section version tracker.
// ============================================================================
package psi_svt_pkg;

   // Default table capacity in sections.
   localparam int MAX_SECTIONS_DEF = 256;

   // Function codes of a request item.
   typedef enum logic [1:0] {
      FUNC_CHECK  = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_RESET  = 2'd2
   } func_type;

   // Status codes of a response item.
   typedef enum logic [2:0] {
      STAT_IGNORE   = 3'd0,
      STAT_INITIAL  = 3'd1,
      STAT_CHANGE   = 3'd2,
      STAT_PRESENT  = 3'd3,
      STAT_APPEND   = 3'd4,
      STAT_REMOVED  = 3'd5,
      STAT_REJECTED = 3'd6,
      STAT_RESET    = 3'd7
   } status_type;

   // Sequencer states.
   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // Outcome of one request, handed from the decision logic to the state update.
   typedef struct packed {
      status_type status;
      logic       start;   // begin a new table with this section only
      logic       wipe;    // drop the table entirely
      logic       append;  // mark this section received and store its CRC
      logic       remove;  // clear the received mark of this section
   } decision_type;

endpackage

@@ rtl/core/psi_svt_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// psi_svt_if
// Request and response channel interfaces of the PSI section version tracker.
// ============================================================================
interface psi_svt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [4:0]  table_version;
   logic [7:0]  section_number;
   logic [7:0]  last_section_number;
   logic [31:0] section_crc;

   modport source (
      output valid, func, table_version, section_number, last_section_number,
             section_crc,
      input  ready
   );
   modport sink (
      input  valid, func, table_version, section_number, last_section_number,
             section_crc,
      output ready
   );
endinterface

interface psi_svt_rsp_if;
   import psi_svt_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   logic       table_complete;
   logic [7:0] current_last;

   modport source (
      output valid, status, table_complete, current_last,
      input  ready
   );
   modport sink (
      input  valid, status, table_complete, current_last,
      output ready
   );
endinterface

@@ rtl/core/psi_svt_crc_mem.sv @@
`timescale 1ns / 1ps
// ============================================================================
// psi_svt_crc_mem
// Section CRC store: one write port, one read port, registered read data.
// ============================================================================
module psi_svt_crc_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/core/psi_svt_decide.sv @@
`timescale 1ns / 1ps
// ============================================================================
// psi_svt_decide
// Classifies one request against the held table state and the stored CRC.
// ============================================================================
module psi_svt_decide #(
   parameter int MAX_SECTIONS = psi_svt_pkg::MAX_SECTIONS_DEF
) (
   input  logic [1:0]                 func,
   input  logic [4:0]                 table_version,
   input  logic [7:0]                 section_number,
   input  logic [7:0]                 last_section_number,
   input  logic [31:0]                section_crc,
   input  logic                       have_table,
   input  logic [4:0]                 held_version,
   input  logic [7:0]                 held_last,
   input  logic                       flag,
   input  logic [31:0]                stored_crc,
   output psi_svt_pkg::decision_type  decision
);
   import psi_svt_pkg::*;

   localparam logic [8:0] LAST_LIMIT = 9'(MAX_SECTIONS);

   always_comb begin
      decision = '{status: STAT_IGNORE, start: 1'b0, wipe: 1'b0,
                   append: 1'b0, remove: 1'b0};
      unique case (func_type'(func))
         FUNC_CHECK: begin
            // Sections past the announced last one, and tables larger than
            // the store, are dropped without effect.
            if (section_number > last_section_number ||
                {1'b0, last_section_number} >= LAST_LIMIT) begin
               decision.status = STAT_IGNORE;
            end else if (!have_table) begin
               decision.status = STAT_INITIAL;
               decision.start  = 1'b1;
            end else if (table_version != held_version ||
                         last_section_number != held_last ||
                         (flag && stored_crc != section_crc)) begin
               decision.status = STAT_CHANGE;
               decision.start  = 1'b1;
            end else if (flag) begin
               decision.status = STAT_PRESENT;
            end else begin
               decision.status = STAT_APPEND;
               decision.append = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (!have_table || section_number > held_last) begin
               decision.status = STAT_REJECTED;
            end else begin
               decision.status = STAT_REMOVED;
               decision.remove = flag;
            end
         end
         FUNC_RESET: begin
            decision.status = STAT_RESET;
            decision.wipe   = 1'b1;
         end
         default: begin
            decision.status = STAT_IGNORE;
         end
      endcase
   end

endmodule

@@ rtl/core/psi_section_version_tracker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// psi_section_version_tracker
// Tracks version, section reception and section CRCs of one PSI table.
// ============================================================================
// Usage:
//   Request items arrive on req_if (valid/ready). Each carries a function
//   code (check header, remove section, reset table) and a section header.
//   Every request item yields exactly one response item on rsp_if with the
//   status, the table completeness flag and the held last section number.
//
//   Timing: a request item is accepted in the idle state; in that cycle the
//   CRC memory is read at the section number. In the execute state that
//   follows, once the output register is free, the stored CRC is compared,
//   the state and memory are written back and the response is loaded into
//   the output register. The registered read of the CRC memory sets this
//   sequence, and no new item is accepted until the state returns to idle.
//
//   Reset clears the held table and all received marks at once; the CRC
//   memory itself is not cleared. If the receiver stalls, the response
//   waits in the output register and one further request item may still be
//   accepted; its evaluation then holds until the output register frees.
// ============================================================================
module psi_section_version_tracker #(
   parameter int MAX_SECTIONS = psi_svt_pkg::MAX_SECTIONS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   psi_svt_req_if.sink      req_if,
   psi_svt_rsp_if.source    rsp_if
);
   import psi_svt_pkg::*;

   localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

   // Sequencer state.
   state_type state_ff, state_in;

   // Captured request item.
   logic [1:0]  func_ff;
   logic [4:0]  ver_ff;
   logic [7:0]  sec_ff;
   logic [7:0]  last_ff;
   logic [31:0] crc_ff;

   // Table state. The received marks live in flip-flops so that reset and a
   // table restart clear them all at once; the CRCs live in the memory.
   logic                    have_ff, have_in;
   logic [4:0]              held_ver_ff, held_ver_in;
   logic [7:0]              held_last_ff, held_last_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [MAX_SECTIONS-1:0] flags_ff;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic       rsp_complete_ff, rsp_complete_in;
   logic [7:0] rsp_last_ff;

   logic         accept;
   logic         fire;
   logic         mem_rd;
   logic [31:0]  stored_crc;
   logic [IDX_W-1:0] idx;
   logic         flag;
   decision_type decision;

   assign idx = sec_ff[IDX_W-1:0];
   // Indexes past the store only occur on requests that the decision logic
   // rejects or ignores; they read as not received.
   assign flag = (32'(idx) < MAX_SECTIONS) ? flags_ff[idx] : 1'b0;

   // Next state and handshake. The next request cannot be read from memory
   // before the current one has written back, since acceptance waits for the
   // return to idle; no forwarding is needed.
   always_comb begin
      state_in = state_ff;
      accept   = 1'b0;
      fire     = 1'b0;
      mem_rd   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            accept = req_if.valid;
            mem_rd = req_if.valid;
            if (req_if.valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               fire     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_if.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_if.func;
         ver_ff  <= req_if.table_version;
         sec_ff  <= req_if.section_number;
         last_ff <= req_if.last_section_number;
         crc_ff  <= req_if.section_crc;
      end
   end

   psi_svt_crc_mem #(
      .DEPTH  (MAX_SECTIONS),
      .ADDR_W (IDX_W)
   ) u_crc_mem (
      .clock   (clock),
      .rd_en   (mem_rd),
      .rd_addr (req_if.section_number[IDX_W-1:0]),
      .rd_data (stored_crc),
      .wr_en   (fire && (decision.start || decision.append)),
      .wr_addr (idx),
      .wr_data (crc_ff)
   );

   psi_svt_decide #(
      .MAX_SECTIONS (MAX_SECTIONS)
   ) u_decide (
      .func                (func_ff),
      .table_version       (ver_ff),
      .section_number      (sec_ff),
      .last_section_number (last_ff),
      .section_crc         (crc_ff),
      .have_table          (have_ff),
      .held_version        (held_ver_ff),
      .held_last           (held_last_ff),
      .flag                (flag),
      .stored_crc          (stored_crc),
      .decision            (decision)
   );

   // State after this item, also used for the completeness flag.
   always_comb begin
      have_in      = have_ff;
      held_ver_in  = held_ver_ff;
      held_last_in = held_last_ff;
      count_in     = count_ff;
      priority if (decision.wipe) begin
         have_in      = 1'b0;
         held_ver_in  = '0;
         held_last_in = '0;
         count_in     = '0;
      end else if (decision.start) begin
         have_in      = 1'b1;
         held_ver_in  = ver_ff;
         held_last_in = last_ff;
         count_in     = CNT_W'(1);
      end else if (decision.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (decision.remove) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
      rsp_complete_in = have_in &&
                        (9'(count_in) == ({1'b0, held_last_in} + 9'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         held_ver_ff  <= '0;
         held_last_ff <= '0;
         count_ff     <= '0;
      end else if (fire) begin
         have_ff      <= have_in;
         held_ver_ff  <= held_ver_in;
         held_last_ff <= held_last_in;
         count_ff     <= count_in;
      end
   end

   // Received marks: a restart clears all of them and then marks this one.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (fire) begin
         if (decision.wipe) begin
            flags_ff <= '0;
         end else if (decision.start) begin
            flags_ff <= MAX_SECTIONS'(1) << idx;
         end else if (decision.append) begin
            flags_ff[idx] <= 1'b1;
         end else if (decision.remove) begin
            flags_ff[idx] <= 1'b0;
         end
      end
   end

   // Output register: holds the response until the receiver takes it.
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff   <= decision.status;
         rsp_complete_ff <= rsp_complete_in;
         rsp_last_ff     <= held_last_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.table_complete = rsp_complete_ff;
   assign rsp_if.current_last   = rsp_last_ff;

endmodule

@@ tb/sv/tb_psi_section_version_tracker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_psi_section_version_tracker
// Self-checking testbench for the PSI section version tracker.
// ============================================================================
// A scoreboard object keeps its own copy of the table: the held version, the
// held last section number, a received mark and a CRC word per section, and
// the count of received sections. Each request item that the block accepts
// is run through that copy, and the answer it should give is queued. Each
// answer item that leaves the block is compared field by field with the
// oldest queued answer.
//
// The stimulus starts with a short directed sequence that covers the field
// extremes, every function code and every corner of the decision logic. It
// then sends table "episodes": a version and last section number are chosen,
// every section of the table is sent once in shuffled order with its own
// CRC, and repeats, removals, CRC clashes and random noise are mixed in.
// The sender works in bursts and the receiver stalls on shifting patterns.
// ============================================================================
module tb_psi_section_version_tracker;
   import psi_svt_pkg::*;

   // Function code that the block does not define; it must answer ignore.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 1100;
   localparam int LONG_HOLD      = 120;
   localparam int DRAIN_CYCLES   = 10;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PRINT_LIMIT    = 40;

   // One request item as the sender drives it.
   typedef struct packed {
      logic [1:0]  func;
      logic [4:0]  table_version;
      logic [7:0]  section_number;
      logic [7:0]  last_section_number;
      logic [31:0] section_crc;
   } section_header_type;

   // One answer item as the block returns it.
   typedef struct packed {
      status_type  status;
      logic        table_complete;
      logic [7:0]  current_last;
   } tracker_answer_type;

   // The scoreboard holds an independent copy of the table state. Requests
   // are folded into it as they are accepted, which yields the answer the
   // block must give; answers are then matched in arrival order.
   class section_scoreboard;
      bit                 have_table;
      logic [4:0]         held_version;
      logic [7:0]         held_last;
      bit                 received [256];
      logic [31:0]        crc_store [256];
      int unsigned        received_count;
      tracker_answer_type tracker_answers [$];
      int unsigned        errors;

      function new();
         errors = 0;
         wipe_table();
      endfunction

      function void wipe_table();
         have_table     = 0;
         held_version   = '0;
         held_last      = '0;
         received_count = 0;
         foreach (received[i]) received[i] = 0;
      endfunction

      function void start_table(section_header_type h);
         foreach (received[i]) received[i] = 0;
         have_table                    = 1;
         held_version                  = h.table_version;
         held_last                     = h.last_section_number;
         received[h.section_number]    = 1;
         crc_store[h.section_number]   = h.section_crc;
         received_count                = 1;
      endfunction

      function status_type check_header(section_header_type h);
         logic [7:0] sec;
         sec = h.section_number;
         // A section beyond its own last number is not part of any table.
         if (sec > h.last_section_number) return STAT_IGNORE;
         if (!have_table) begin
            start_table(h);
            return STAT_INITIAL;
         end
         // A new version, a new size, or a clashing CRC starts over.
         if (h.table_version != held_version || h.last_section_number != held_last ||
             (received[sec] && crc_store[sec] != h.section_crc)) begin
            start_table(h);
            return STAT_CHANGE;
         end
         if (received[sec]) return STAT_PRESENT;
         received[sec]  = 1;
         crc_store[sec] = h.section_crc;
         received_count++;
         return STAT_APPEND;
      endfunction

      function status_type remove_section(logic [7:0] sec);
         if (!have_table || sec > held_last) return STAT_REJECTED;
         if (received[sec]) begin
            received[sec] = 0;
            received_count--;
         end
         return STAT_REMOVED;
      endfunction

      // Applies one accepted request and queues the answer it must produce.
      function void track_request(section_header_type h);
         tracker_answer_type a;
         case (h.func)
            FUNC_CHECK:  a.status = check_header(h);
            FUNC_REMOVE: a.status = remove_section(h.section_number);
            FUNC_RESET: begin
               wipe_table();
               a.status = STAT_RESET;
            end
            default:     a.status = STAT_IGNORE;
         endcase
         a.table_complete = have_table && (received_count == int'(held_last) + 1);
         a.current_last   = held_last;
         tracker_answers.push_back(a);
      endfunction

      task report(string what);
         if (errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_answer(tracker_answer_type got);
         tracker_answer_type want;
         if (tracker_answers.size() == 0) begin
            report($sformatf("answer %s/%0b/%0d with no request outstanding",
                             got.status.name(), got.table_complete, got.current_last));
            return;
         end
         want = tracker_answers.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %s, expected %s", got.status.name(), want.status.name()));
         if (got.table_complete !== want.table_complete)
            report($sformatf("table_complete %b, expected %b",
                             got.table_complete, want.table_complete));
         if (got.current_last !== want.current_last)
            report($sformatf("current_last %0d, expected %0d",
                             got.current_last, want.current_last));
      endtask

      function int pending();
         return tracker_answers.size();
      endfunction

      task close_out();
         if (tracker_answers.size() != 0)
            report($sformatf("%0d answers never arrived", tracker_answers.size()));
      endtask
   endclass

   logic clock;
   logic reset;

   psi_svt_req_if req_if ();
   psi_svt_rsp_if rsp_if ();

   psi_section_version_tracker dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   section_scoreboard sb = new();

   // Sender pacing state. A burst runs without gaps; between bursts the
   // sender may drop valid for a random gap unless the current episode is quiet.
   int          burst_left     = 0;
   bit          sender_quiet   = 0;
   int unsigned items_sent     = 0;

   // The stimulus bumps stall_requests to ask the receiver for a long hold.
   int unsigned stall_requests = 0;
   int unsigned stall_served   = 0;

   // Tallies for the closing summary.
   int unsigned answers_seen   = 0;
   int unsigned complete_seen  = 0;
   int unsigned status_seen [8];
   int unsigned cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Monitor. The answer is handled before the request, because an answer
   // taken at this edge always belongs to an earlier request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_answer('{rsp_if.status, rsp_if.table_complete, rsp_if.current_last});
            answers_seen++;
            status_seen[rsp_if.status]++;
            if (rsp_if.table_complete) complete_seen++;
         end
         if (req_if.valid && req_if.ready)
            sb.track_request('{req_if.func, req_if.table_version, req_if.section_number,
                               req_if.last_section_number, req_if.section_crc});
      end
   end

   // Receiver. It changes its stall pattern after each random span, and it
   // serves a long hold when the stimulus asks for one, so that the block
   // fills up and has to push back on its request side.
   initial begin
      int mode;
      int span;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 80);
         repeat (span) begin
            if (stall_served != stall_requests) begin
               stall_served++;
               rsp_if.ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= 1'($urandom_range(0, 1));
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= ((cycle_count % 8) < 5);
            endcase
            @(posedge clock);
         end
      end
   end

   // Offers one item and returns at the edge where it is accepted. Valid is
   // left high so that the next item follows without a gap.
   task automatic send_item(input logic [1:0] func, input logic [4:0] version,
                            input logic [7:0] section, input logic [7:0] last,
                            input logic [31:0] crc);
      int gap;
      if (burst_left == 0) begin
         gap = sender_quiet ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_if.valid               <= 1'b1;
      req_if.func                <= func;
      req_if.table_version       <= version;
      req_if.section_number      <= section;
      req_if.last_section_number <= last;
      req_if.section_crc         <= crc;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      items_sent++;
   endtask

   // Stops offering and waits until every queued answer has come back. The
   // first edge makes sure the item just accepted has been noted.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // A request that does not belong to the current table: random checks,
   // out-of-range headers, stray removals, resets and the unused code.
   task automatic send_noise();
      logic [7:0] last;
      case ($urandom_range(0, 9))
         0, 1, 2, 3:
            send_item(FUNC_CHECK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), $urandom);
         4, 5: begin
            last = 8'($urandom_range(0, 254));
            send_item(FUNC_CHECK, 5'($urandom_range(0, 31)),
                      8'($urandom_range(last + 1, 255)), last, $urandom);
         end
         6, 7:
            send_item(FUNC_REMOVE, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), $urandom);
         8:
            send_item(FUNC_RESET, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), $urandom);
         default:
            send_item(FUNC_UNUSED, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), $urandom);
      endcase
   endtask

   // One table episode: every section of a table of the given size is sent
   // once in shuffled order, with repeats, removals and clashes mixed in
   // unless the episode is kept clean so that a large table can complete.
   task automatic run_episode(input logic [4:0] version, input logic [7:0] last,
                              input bit clean);
      logic [31:0] crc_of [256];
      int          order [256];
      int          idx;
      int          j;
      int          tmp;
      int          pick;
      int          roll;
      for (idx = 0; idx <= last; idx++) begin
         crc_of[idx] = $urandom;
         order[idx]  = idx;
      end
      for (idx = int'(last); idx > 0; idx--) begin
         j          = $urandom_range(0, idx);
         tmp        = order[idx];
         order[idx] = order[j];
         order[j]   = tmp;
      end
      for (idx = 0; idx <= last; idx++) begin
         roll = $urandom_range(0, 99);
         if (idx > 0 && roll < 10) begin
            // Resend an earlier section: present, or append if it was removed.
            pick = order[$urandom_range(0, idx - 1)];
            send_item(FUNC_CHECK, version, 8'(pick), last, crc_of[pick]);
         end else if (!clean && roll < 18) begin
            send_noise();
         end else if (!clean && roll < 24) begin
            // Mostly inside the table, sometimes past its end.
            pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, last);
            send_item(FUNC_REMOVE, version, 8'(pick), last, 32'd0);
         end else if (!clean && idx > 0 && roll < 27) begin
            // A changed CRC for a section already held restarts the table.
            pick         = order[$urandom_range(0, idx - 1)];
            crc_of[pick] = crc_of[pick] ^ (32'h1 << $urandom_range(0, 31));
            send_item(FUNC_CHECK, version, 8'(pick), last, crc_of[pick]);
         end
         send_item(FUNC_CHECK, version, 8'(order[idx]), last, crc_of[order[idx]]);
      end
      if (!clean && $urandom_range(0, 9) == 0)
         send_item(FUNC_RESET, version, 8'd0, last, 32'd0);
   endtask

   initial begin
      logic [4:0] version;
      logic [7:0] last;
      int         roll;
      int         episodes;

      reset                      <= 1'b1;
      req_if.valid               <= 1'b0;
      req_if.func                <= FUNC_CHECK;
      req_if.table_version       <= '0;
      req_if.section_number      <= '0;
      req_if.last_section_number <= '0;
      req_if.section_crc         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Nothing is held yet: removal is rejected, the unused
      // function code and a reset are answered without effect.
      send_item(FUNC_REMOVE, 5'd0, 8'd0, 8'd0, 32'd0);
      send_item(FUNC_UNUSED, 5'd31, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send_item(FUNC_RESET, 5'd0, 8'd0, 8'd0, 32'd0);
      // A section beyond its last number is ignored.
      send_item(FUNC_CHECK, 5'd3, 8'd5, 8'd3, 32'h1234_5678);
      // First table of one section, then the same again, then a CRC clash.
      send_item(FUNC_CHECK, 5'd0, 8'd0, 8'd0, 32'h0000_0000);
      send_item(FUNC_CHECK, 5'd0, 8'd0, 8'd0, 32'h0000_0000);
      send_item(FUNC_CHECK, 5'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
      // New version with the largest table, then appends.
      send_item(FUNC_CHECK, 5'd31, 8'd255, 8'd255, 32'hFFFF_FFFF);
      send_item(FUNC_CHECK, 5'd31, 8'd0, 8'd255, 32'h0000_0000);
      send_item(FUNC_CHECK, 5'd31, 8'd128, 8'd255, 32'hA5A5_5A5A);
      // A removed section keeps its CRC but comes back as an append.
      send_item(FUNC_REMOVE, 5'd31, 8'd128, 8'd255, 32'd0);
      send_item(FUNC_CHECK, 5'd31, 8'd128, 8'd255, 32'hA5A5_5A5A);
      // Removal of a section never received is accepted without change.
      send_item(FUNC_REMOVE, 5'd31, 8'd7, 8'd255, 32'd0);
      // A new last number restarts the table.
      send_item(FUNC_CHECK, 5'd31, 8'd1, 8'd254, 32'h5A5A_A5A5);
      // Removal past the held last number is rejected.
      send_item(FUNC_REMOVE, 5'd31, 8'd255, 8'd254, 32'd0);
      // Out-of-range header while a table is held.
      send_item(FUNC_CHECK, 5'd31, 8'd200, 8'd100, 32'hDEAD_BEEF);
      send_item(FUNC_RESET, 5'd31, 8'd0, 8'd0, 32'd0);
      send_item(FUNC_REMOVE, 5'd31, 8'd0, 8'd0, 32'd0);
      // Two-section table completes, loses a section, then the unused code.
      send_item(FUNC_CHECK, 5'd5, 8'd1, 8'd1, 32'h0F0F_0F0F);
      send_item(FUNC_CHECK, 5'd5, 8'd0, 8'd1, 32'hF0F0_F0F0);
      send_item(FUNC_REMOVE, 5'd5, 8'd1, 8'd1, 32'd0);
      send_item(FUNC_UNUSED, 5'd5, 8'd0, 8'd1, 32'd0);
      wait_drained();

      // Random part. The first episode is the full 256-section table, sent
      // without gaps while the receiver is asked for a long hold.
      version      = 5'($urandom_range(0, 31));
      sender_quiet = 1;
      stall_requests++;
      run_episode(version, 8'd255, 1'b1);
      episodes = 1;
      while (items_sent < RANDOM_ITEMS + 25) begin
         if ($urandom_range(0, 3) != 0) version = 5'($urandom_range(0, 31));
         roll = $urandom_range(0, 99);
         if (roll < 70)      last = 8'($urandom_range(0, 7));
         else if (roll < 96) last = 8'($urandom_range(8, 31));
         else                last = 8'($urandom_range(32, 255));
         sender_quiet = ($urandom_range(0, 3) == 0);
         if (episodes % 25 == 12) stall_requests++;
         run_episode(version, last, last >= 32);
         if ($urandom_range(0, 7) == 0) wait_drained();
         episodes++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close_out();

      $display("Run covered %0d requests in %0d table episodes; %0d answers, %0d complete.",
               items_sent, episodes, answers_seen, complete_seen);
      $display("Answers: ignore %0d, initial %0d, change %0d, present %0d, append %0d, %s",
               status_seen[STAT_IGNORE], status_seen[STAT_INITIAL],
               status_seen[STAT_CHANGE], status_seen[STAT_PRESENT],
               status_seen[STAT_APPEND],
               $sformatf("removed %0d, rejected %0d, reset %0d.",
                         status_seen[STAT_REMOVED], status_seen[STAT_REJECTED],
                         status_seen[STAT_RESET]));
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/psi_svt_pkg.sv
rtl/core/psi_svt_if.sv
rtl/core/psi_svt_crc_mem.sv
rtl/core/psi_svt_decide.sv
rtl/core/psi_section_version_tracker.sv
tb/sv/tb_psi_section_version_tracker.sv
